[rtl/tqc_pkg.sv]
// ----------------------------------------------------------------------------
// tqc_pkg
// Shared types and constants for the timeout queue with cancel.
// ----------------------------------------------------------------------------
package tqc_pkg;

  localparam int TIMERS   = 64;               // table slots
  localparam int IDX_W    = $clog2(TIMERS);
  localparam int MAX_FIRE = 64;               // fired entries per tick
  localparam int CNT_W    = $clog2(MAX_FIRE);
  localparam int DL_W     = 48;
  localparam int ID_W     = 32;
  localparam int DLY_W    = 32;
  localparam int TAG_W    = 16;
  localparam int SLOT_W   = DL_W + ID_W + 2 * TAG_W;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ADD_OK     = 2'd0,
    KIND_ADD_FULL   = 2'd1,
    KIND_CLEAR_DONE = 2'd2,
    KIND_FIRED      = 2'd3
  } kind_e;

  // controller -> datapath
  typedef struct packed {
    logic  load_in;     // latch the accepted item
    logic  tick_now;    // advance the millisecond clock
    logic  scan_start;  // start a pass over the table
    logic  write_slot;  // store the add into the free slot found
    logic  take_best;   // retire the best expired entry into the pending result
    logic  emit;        // load the output register
    kind_e emit_kind;
    logic  emit_last;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;    // pass finished this cycle
    logic found;        // free slot (add) or expired entry (tick) found
    logic out_free;     // output register can take a result this cycle
  } dp_sts_t;

endpackage

[rtl/tqc_ram.sv]
// ----------------------------------------------------------------------------
// tqc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tqc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/tqc_dp.sv]
// ----------------------------------------------------------------------------
// tqc_dp
// Datapath: slot table, valid bits, clock, id counter, table scan engine,
// pending fired entry and output register.
// ----------------------------------------------------------------------------
module tqc_dp
  import tqc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_cmd_t        cmd_i,
  output dp_sts_t          sts_o,
  input  logic [1:0]       in_cmd_i,
  input  logic [DLY_W-1:0] in_delay_i,
  input  logic [TAG_W-1:0] in_lis_i,
  input  logic [TAG_W-1:0] in_msg_i,
  input  logic [ID_W-1:0]  in_cid_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [1:0]       out_kind_o,
  output logic [ID_W-1:0]  out_id_o,
  output logic [TAG_W-1:0] out_lis_o,
  output logic [TAG_W-1:0] out_msg_o,
  output logic             out_last_o
);

  // latched item
  cmd_e             cmd_q;
  logic [DLY_W-1:0] delay_q;
  logic [TAG_W-1:0] lis_q, msg_q;
  logic [ID_W-1:0]  cid_q;

  logic [DL_W-1:0]  now_q;
  logic [ID_W-1:0]  next_id_q;
  logic [TIMERS-1:0] valid_q, valid_d;

  // scan engine
  logic             run_q;
  logic [IDX_W:0]   rd_idx_q;
  logic             chk_vld_q;
  logic [IDX_W-1:0] chk_idx_q;
  logic             rd_end;
  logic             scan_done;

  // best candidate of the current pass
  logic             found_q;
  logic [IDX_W-1:0] best_idx_q;
  logic [DL_W-1:0]  best_dl_q;
  logic [ID_W-1:0]  best_id_q;
  logic [TAG_W-1:0] best_lis_q, best_msg_q;

  // fired entry waiting for its result slot
  logic [ID_W-1:0]  pend_id_q;
  logic [TAG_W-1:0] pend_lis_q, pend_msg_q;

  // output register
  logic             out_valid_q;
  logic [1:0]       out_kind_q;
  logic [ID_W-1:0]  out_id_q;
  logic [TAG_W-1:0] out_lis_q, out_msg_q;
  logic             out_last_q;

  // slot memory
  logic [SLOT_W-1:0] wdata, rdata;
  logic [DL_W-1:0]   r_dl;
  logic [ID_W-1:0]   r_id;
  logic [TAG_W-1:0]  r_lis, r_msg;
  logic [DL_W:0]     dl_sum;
  logic [DL_W-1:0]   dl_sat;
  logic              r_v;
  logic              hit_free, hit_clear, hit_fire;

  tqc_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(TIMERS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.write_slot),
    .waddr_i(best_idx_q),
    .wdata_i(wdata),
    .raddr_i(rd_idx_q[IDX_W-1:0]),
    .rdata_o(rdata)
  );

  // saturating deadline
  assign dl_sum = {1'b0, now_q} + {{(DL_W + 1 - DLY_W){1'b0}}, delay_q};
  assign dl_sat = dl_sum[DL_W] ? {DL_W{1'b1}} : dl_sum[DL_W-1:0];
  assign wdata  = {msg_q, lis_q, next_id_q, dl_sat};

  assign {r_msg, r_lis, r_id, r_dl} = rdata;
  assign r_v = valid_q[chk_idx_q];

  // per-entry checks on the slot just read
  assign hit_free  = chk_vld_q && (cmd_q == CMD_ADD) && !r_v && !found_q;
  assign hit_clear = chk_vld_q && (cmd_q == CMD_CLEAR) && r_v && (r_id == cid_q);
  assign hit_fire  = chk_vld_q && (cmd_q == CMD_TICK) && r_v && (r_dl <= now_q) &&
                     (!found_q || (r_dl < best_dl_q) ||
                      ((r_dl == best_dl_q) && (r_id < best_id_q)));

  assign rd_end    = (rd_idx_q == (IDX_W + 1)'(TIMERS));
  assign scan_done = run_q && rd_end && !chk_vld_q;

  // valid bit updates
  always_comb begin
    valid_d = valid_q;
    if (hit_clear) begin
      valid_d[chk_idx_q] = 1'b0;
    end
    if (cmd_i.take_best) begin
      valid_d[best_idx_q] = 1'b0;
    end
    if (cmd_i.write_slot) begin
      valid_d[best_idx_q] = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      now_q       <= '0;
      next_id_q   <= '0;
      run_q       <= 1'b0;
      rd_idx_q    <= '0;
      chk_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (cmd_i.tick_now) begin
        now_q <= now_q + DL_W'(1);
      end
      if (cmd_i.write_slot) begin
        next_id_q <= next_id_q + ID_W'(1);
      end
      if (cmd_i.scan_start) begin
        run_q     <= 1'b1;
        rd_idx_q  <= '0;
        chk_vld_q <= 1'b0;
        found_q   <= 1'b0;
      end else begin
        if (scan_done) begin
          run_q <= 1'b0;
        end
        chk_vld_q <= run_q && !rd_end;
        if (run_q && !rd_end) begin
          rd_idx_q <= rd_idx_q + (IDX_W + 1)'(1);
        end
        if (hit_free || hit_fire) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_q   <= cmd_e'(in_cmd_i);
      delay_q <= in_delay_i;
      lis_q   <= in_lis_i;
      msg_q   <= in_msg_i;
      cid_q   <= in_cid_i;
    end
    chk_idx_q <= rd_idx_q[IDX_W-1:0];
    if (hit_free || hit_fire) begin
      best_idx_q <= chk_idx_q;
      best_dl_q  <= r_dl;
      best_id_q  <= r_id;
      best_lis_q <= r_lis;
      best_msg_q <= r_msg;
    end
    if (cmd_i.take_best) begin
      pend_id_q  <= best_id_q;
      pend_lis_q <= best_lis_q;
      pend_msg_q <= best_msg_q;
    end
    if (cmd_i.emit) begin
      out_kind_q <= cmd_i.emit_kind;
      out_last_q <= cmd_i.emit_last;
      case (cmd_i.emit_kind)
        KIND_ADD_OK: begin
          out_id_q  <= next_id_q;
          out_lis_q <= '0;
          out_msg_q <= '0;
        end
        KIND_ADD_FULL: begin
          out_id_q  <= '0;
          out_lis_q <= '0;
          out_msg_q <= '0;
        end
        KIND_CLEAR_DONE: begin
          out_id_q  <= cid_q;
          out_lis_q <= '0;
          out_msg_q <= '0;
        end
        KIND_FIRED: begin
          out_id_q  <= pend_id_q;
          out_lis_q <= pend_lis_q;
          out_msg_q <= pend_msg_q;
        end
        default: begin
          out_id_q  <= '0;
          out_lis_q <= '0;
          out_msg_q <= '0;
        end
      endcase
    end
  end

  assign sts_o.scan_done = scan_done;
  assign sts_o.found     = found_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_id_o    = out_id_q;
  assign out_lis_o   = out_lis_q;
  assign out_msg_o   = out_msg_q;
  assign out_last_o  = out_last_q;

endmodule

[rtl/tqc_ctrl.sv]
// ----------------------------------------------------------------------------
// tqc_ctrl
// Controller: accepts items, sequences table passes and result transfers,
// holds the enable register.
// ----------------------------------------------------------------------------
module tqc_ctrl
  import tqc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_cmd_i,
  output logic       in_ready_o,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  dp_sts_t    sts_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_SCAN,
    ST_ADD_EMIT,
    ST_CLR_SCAN,
    ST_CLR_EMIT,
    ST_FIRE_SCAN,
    ST_FIRE_DEC,
    ST_FIRE_LAST
  } state_e;

  state_e           state_q;
  logic             enable_q;
  logic             pend_q;     // a fired entry awaits its transfer
  logic [CNT_W-1:0] n_q;        // entries fired in this tick
  logic             accept;
  logic             dec_go;
  logic             n_full;

  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign dec_go = !pend_q || sts_i.out_free;
  assign n_full = (n_q == CNT_W'(MAX_FIRE - 1));

  assign in_ready_o = (state_q == ST_IDLE);

  // command decode
  always_comb begin
    cmd_o           = '0;
    cmd_o.emit_kind = KIND_FIRED;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load_in = 1'b1;
          case (cmd_e'(in_cmd_i))
            CMD_ADD, CMD_CLEAR: cmd_o.scan_start = 1'b1;
            CMD_TICK: begin
              cmd_o.tick_now   = 1'b1;
              cmd_o.scan_start = enable_q;
            end
            default: ;
          endcase
        end
      end
      ST_ADD_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_last  = 1'b1;
          cmd_o.emit_kind  = sts_i.found ? KIND_ADD_OK : KIND_ADD_FULL;
          cmd_o.write_slot = sts_i.found;
        end
      end
      ST_CLR_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          cmd_o.emit_kind = KIND_CLEAR_DONE;
        end
      end
      ST_FIRE_DEC: begin
        if (dec_go) begin
          cmd_o.emit       = pend_q;
          cmd_o.emit_last  = !sts_i.found;
          cmd_o.take_best  = sts_i.found;
          cmd_o.scan_start = sts_i.found && !n_full;
        end
      end
      ST_FIRE_LAST: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // state and registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      enable_q <= 1'b0;
      pend_q   <= 1'b0;
      n_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (cmd_e'(in_cmd_i))
              CMD_ADD:   state_q <= ST_ADD_SCAN;
              CMD_CLEAR: state_q <= ST_CLR_SCAN;
              CMD_TICK: begin
                pend_q <= 1'b0;
                n_q    <= '0;
                if (enable_q) begin
                  state_q <= ST_FIRE_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        ST_ADD_SCAN: if (sts_i.scan_done) state_q <= ST_ADD_EMIT;
        ST_ADD_EMIT: if (sts_i.out_free) state_q <= ST_IDLE;
        ST_CLR_SCAN: if (sts_i.scan_done) state_q <= ST_CLR_EMIT;
        ST_CLR_EMIT: if (sts_i.out_free) state_q <= ST_IDLE;
        ST_FIRE_SCAN: if (sts_i.scan_done) state_q <= ST_FIRE_DEC;
        ST_FIRE_DEC: begin
          if (dec_go) begin
            if (sts_i.found) begin
              pend_q  <= 1'b1;
              n_q     <= n_q + CNT_W'(1);
              state_q <= n_full ? ST_FIRE_LAST : ST_FIRE_SCAN;
            end else begin
              pend_q  <= 1'b0;
              state_q <= ST_IDLE;
            end
          end
        end
        ST_FIRE_LAST: begin
          if (sts_i.out_free) begin
            pend_q  <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/timeout_queue_with_cancel_top.sv]
// Add and clear each take one table pass to their result. A tick makes one full
// pass of the single-read slot RAM per fired entry, plus a closing pass that finds
// none unless MAX_FIRE entries fired; a disabled tick makes no pass.
// One item is in work at a time; results leave through an output register.
// Reset (rst_ni, async low) empties the table, zeroes clock and id, disables firing.
// ----------------------------------------------------------------------------
// timeout_queue_with_cancel_top
// Table of one-shot timeouts with add, cancel by id and millisecond tick that
// fires expired entries earliest deadline first.
// ----------------------------------------------------------------------------
module timeout_queue_with_cancel_top
  import tqc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,     // enable
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,    // delay_ms, listener_tag, message_tag, clear_id
  input  logic [1:0]  s_axis_tuser,    // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,    // timer_id, fired_listener, fired_message
  output logic [1:0]  m_axis_tuser,    // kind
  output logic        m_axis_tlast     // last
);

  ctrl_cmd_t        cmd;
  dp_sts_t          sts;
  logic [ID_W-1:0]  out_id;
  logic [TAG_W-1:0] out_lis, out_msg;

  tqc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tqc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_cmd_i   (s_axis_tuser),
    .in_delay_i (s_axis_tdata[31:0]),
    .in_lis_i   (s_axis_tdata[47:32]),
    .in_msg_i   (s_axis_tdata[63:48]),
    .in_cid_i   (s_axis_tdata[95:64]),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_kind_o (m_axis_tuser),
    .out_id_o   (out_id),
    .out_lis_o  (out_lis),
    .out_msg_o  (out_msg),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {out_msg, out_lis, out_id};

  // results are only loaded into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("result loaded over an untaken result");

  // an add is stored only into a slot the pass found free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.write_slot |-> sts.found && !sts.scan_done)
    else $error("slot written without a free slot");

  // only a found expired entry is retired
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.take_best |-> sts.found)
    else $error("entry retired without a candidate");

endmodule
